// ===== sv/tgarle_pkg.sv =====
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder package
// Widths, packet codes, register indexes and reset values.
// ---------------------------------------------------------------------------
package tgarle_pkg;

   localparam int MAX_PIXEL_BYTES  = 4;
   localparam int PIXEL_COUNT_BITS = 25;
   localparam int PIXEL_BITS       = 8 * MAX_PIXEL_BYTES;
   localparam int NB_BITS          = 3;
   localparam int CSR_DATA_BITS    = PIXEL_COUNT_BITS;
   localparam int CSR_INDEX_BITS   = 2;

   localparam int RUN_FLAG_BIT     = 7;
   localparam logic [6:0] RUN_LEN_MASK = 7'd127;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PIXEL_BYTES   = 2'd0,
      CSR_RLE_MODE      = 2'd1,
      CSR_SWAP_RED_BLUE = 2'd2,
      CSR_TOTAL_PIXELS  = 2'd3
   } csr_index_type;

   localparam logic [NB_BITS-1:0]          RST_PIXEL_BYTES  = 3'd3;
   localparam logic                        RST_RLE_MODE     = 1'b1;
   localparam logic                        RST_SWAP         = 1'b1;
   localparam logic [PIXEL_COUNT_BITS-1:0] RST_TOTAL_PIXELS = 25'd1;

endpackage

// ===== sv/tgarle_if.sv =====
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder channels
// Byte request channel and pixel response channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface tgarle_req_if import tgarle_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface tgarle_rsp_if import tgarle_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_value;
   logic [7:0]            repeat_count;
   logic                  image_end;
   logic                  run_clipped;

   modport source (output valid, output pixel_value, output repeat_count,
                   output image_end, output run_clipped, input ready);
   modport sink   (input valid, input pixel_value, input repeat_count,
                   input image_end, input run_clipped, output ready);
endinterface

// ===== sv/tga_rle_pixel_decoder_top.sv =====
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder
// Decodes TGA image-data bytes into pixels with repeat counts.
// ---------------------------------------------------------------------------
// Takes one image-data byte per cycle, back to back, unless the response side
// stalls, and gives at most one result per byte: the byte is registered,
// then decoded against the packet and pixel-count state into the result
// register. A run of up to 128 copies leaves as one result with its repeat
// count. The loop through the pixel counter (subtract, clip, add, compare)
// sets the rate of one byte per cycle. Write configuration only while idle.
// ---------------------------------------------------------------------------
module tga_rle_pixel_decoder_top
   import tgarle_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   tgarle_req_if.sink                req_ch,
   tgarle_rsp_if.source              rsp_ch,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [NB_BITS-1:0]          pixel_bytes_ff;
   logic                        rle_mode_ff;
   logic                        swap_ff;
   logic [PIXEL_COUNT_BITS-1:0] total_ff;

   logic       s1_vld_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_start_ff;
   logic       out_ok;
   logic       s1_move;

   logic                        expect_ff, expect_in;
   logic                        is_run_ff, is_run_in;
   logic [7:0]                  left_ff, left_in;
   logic [1:0]                  bip_ff, bip_in;
   logic [PIXEL_BITS-1:0]       gather_ff, gather_in;
   logic [PIXEL_COUNT_BITS-1:0] done_ff, done_in;
   logic                        finished_ff, finished_in;

   logic                        out_vld_ff;
   logic [PIXEL_BITS-1:0]       out_pixel_ff, out_pixel_in;
   logic [7:0]                  out_count_ff, out_count_in;
   logic                        out_end_ff, out_end_in;
   logic                        out_clip_ff, out_clip_in;
   logic                        emit_in;

   logic                        cur_expect, cur_run, cur_finished;
   logic [7:0]                  cur_left;
   logic [1:0]                  cur_bip;
   logic [PIXEL_BITS-1:0]       cur_gather, merged;
   logic [PIXEL_COUNT_BITS-1:0] cur_done, px_left, done_sum;
   logic [NB_BITS-1:0]          nb;
   logic [7:0]                  count, left_after;
   logic                        ignore, complete, clip;

   assign out_ok       = !out_vld_ff || rsp_ch.ready;
   assign s1_move      = s1_vld_ff && out_ok;
   assign req_ch.ready = !s1_vld_ff || out_ok;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_bytes_ff <= RST_PIXEL_BYTES;
         rle_mode_ff    <= RST_RLE_MODE;
         swap_ff        <= RST_SWAP;
         total_ff       <= RST_TOTAL_PIXELS;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PIXEL_BYTES:   pixel_bytes_ff <= csr_wdata[NB_BITS-1:0];
            CSR_RLE_MODE:      rle_mode_ff    <= csr_wdata[0];
            CSR_SWAP_RED_BLUE: swap_ff        <= csr_wdata[0];
            CSR_TOTAL_PIXELS:  total_ff       <= csr_wdata[PIXEL_COUNT_BITS-1:0];
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_byte_ff  <= req_ch.data_byte;
         s1_start_ff <= req_ch.frame_start;
      end
   end

   // decode
   always_comb begin
      if (pixel_bytes_ff == '0) begin
         nb = NB_BITS'(1);
      end else if (pixel_bytes_ff > NB_BITS'(MAX_PIXEL_BYTES)) begin
         nb = NB_BITS'(MAX_PIXEL_BYTES);
      end else begin
         nb = pixel_bytes_ff;
      end

      cur_expect   = s1_start_ff ? 1'b1 : expect_ff;
      cur_run      = s1_start_ff ? 1'b0 : is_run_ff;
      cur_left     = s1_start_ff ? 8'd0 : left_ff;
      cur_bip      = s1_start_ff ? 2'd0 : bip_ff;
      cur_gather   = s1_start_ff ? '0 : gather_ff;
      cur_done     = s1_start_ff ? '0 : done_ff;
      cur_finished = s1_start_ff ? 1'b0 : finished_ff;

      ignore   = cur_finished || (cur_done >= total_ff);
      merged   = cur_gather | ({{(PIXEL_BITS-8){1'b0}}, s1_byte_ff} << {cur_bip, 3'b000});
      complete = !(({1'b0, cur_bip} + 3'd1) < nb);

      count = 8'd1;
      if (rle_mode_ff && cur_run) begin
         count = cur_left;
      end
      if (rle_mode_ff && (count > cur_left)) begin
         count = cur_left;
      end
      left_after = cur_left - count;
      if (count == 8'd0) begin
         count = 8'd1;
      end

      px_left  = total_ff - cur_done;
      clip     = px_left < {{(PIXEL_COUNT_BITS-8){1'b0}}, count};
      out_count_in = clip ? px_left[7:0] : count;
      done_sum = cur_done + {{(PIXEL_COUNT_BITS-8){1'b0}}, out_count_in};
      out_clip_in  = clip;
      out_end_in   = (done_sum == total_ff);

      out_pixel_in = merged;
      if ((nb >= NB_BITS'(3)) && swap_ff) begin
         out_pixel_in = {merged[31:24], merged[7:0], merged[15:8], merged[23:16]};
      end

      expect_in   = cur_expect;
      is_run_in   = cur_run;
      left_in     = cur_left;
      bip_in      = cur_bip;
      gather_in   = cur_gather;
      done_in     = cur_done;
      finished_in = cur_finished;
      emit_in     = 1'b0;

      if (!ignore) begin
         if (rle_mode_ff && cur_expect) begin
            is_run_in = s1_byte_ff[RUN_FLAG_BIT];
            left_in   = {1'b0, s1_byte_ff[6:0] & RUN_LEN_MASK} + 8'd1;
            expect_in = 1'b0;
            bip_in    = 2'd0;
            gather_in = '0;
         end else if (!complete) begin
            bip_in    = cur_bip + 2'd1;
            gather_in = merged;
         end else begin
            bip_in    = 2'd0;
            gather_in = '0;
            emit_in   = 1'b1;
            done_in   = done_sum;
            if (out_end_in) begin
               finished_in = 1'b1;
            end
            if (rle_mode_ff) begin
               left_in = left_after;
               if (left_after == 8'd0) begin
                  expect_in = 1'b1;
               end
            end
         end
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff   <= 1'b1;
         is_run_ff   <= 1'b0;
         left_ff     <= 8'd0;
         bip_ff      <= 2'd0;
         gather_ff   <= '0;
         done_ff     <= '0;
         finished_ff <= 1'b0;
      end else if (s1_move) begin
         expect_ff   <= expect_in;
         is_run_ff   <= is_run_in;
         left_ff     <= left_in;
         bip_ff      <= bip_in;
         gather_ff   <= gather_in;
         done_ff     <= done_in;
         finished_ff <= finished_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (s1_move) begin
         out_vld_ff <= emit_in;
      end else if (rsp_ch.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && emit_in) begin
         out_pixel_ff <= out_pixel_in;
         out_count_ff <= out_count_in;
         out_end_ff   <= out_end_in;
         out_clip_ff  <= out_clip_in;
      end
   end

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.pixel_value  = out_pixel_ff;
   assign rsp_ch.repeat_count = out_count_ff;
   assign rsp_ch.image_end    = out_end_ff;
   assign rsp_ch.run_clipped  = out_clip_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (out_count_ff != 8'd0) && (out_count_ff <= 8'd128))
      else $error("repeat count out of range");

   a_clip_ends: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_clip_ff) |-> out_end_ff)
      else $error("clipped run does not end image");

   a_packet_left: assert property (@(posedge clock) disable iff (reset)
      !expect_ff |-> (left_ff != 8'd0))
      else $error("packet open with nothing left");

   a_finish_set: assert property (@(posedge clock) disable iff (reset)
      (s1_move && emit_in && out_end_in) |=> finished_ff)
      else $error("image end not recorded");

endmodule

// ===== verif/tga_rle_pixel_decoder_top_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder testbench
// Feeds image-data bytes through the request channel under random idling and
// back-pressure. Every accepted byte goes through a local decoder model, and
// its expected pixel runs are matched in order against the response channel.
// A short table of hand-made cases comes first. Random images follow, in
// run-length and raw mode, across pixel sizes and image totals.
// ---------------------------------------------------------------------------
module tga_rle_pixel_decoder_top_tb;
   import tgarle_pkg::*;

   localparam int CNT_W         = PIXEL_COUNT_BITS;
   localparam int RANDOM_ITEMS  = 1750;
   localparam int DRAIN_CYCLES  = 6;
   localparam int HOLD_CYCLES   = 60;
   localparam int QUIET_PHASE   = 1;
   localparam int STALL_PHASE   = 3;
   localparam int LIMIT_NS      = 3_000_000;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_value;
      logic [7:0]            repeat_count;
      logic                  image_end;
      logic                  run_clipped;
   } pixel_run_type;

   typedef enum logic [1:0] {
      ROW_BYTE,
      ROW_REG
   } row_kind_type;

   typedef struct packed {
      row_kind_type             reg_kind;
      csr_index_type            reg_idx;
      logic [CSR_DATA_BITS-1:0] wdata;
      logic [7:0]               data;
      logic                     fs;
      logic                     typed;
      pixel_run_type            want;
   } stim_row_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   tgarle_req_if req_if ();
   tgarle_rsp_if rsp_if ();

   tga_rle_pixel_decoder_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // decoder model: configuration and packet state
   logic [NB_BITS-1:0]    cfg_pb;
   logic                  cfg_rle;
   logic                  cfg_swap;
   logic [CNT_W-1:0]      cfg_total;
   logic                  want_hdr;
   logic                  pkt_run;
   logic [7:0]            pkt_left;
   logic [1:0]            byte_idx;
   logic [PIXEL_BITS-1:0] gather;
   logic [CNT_W-1:0]      done_cnt;
   logic                  img_done;

   pixel_run_type pending_pixels[$];
   stim_row_type  dir_tab[$];

   int  mismatches;
   int  n_bytes, n_used, n_results, n_runs, n_clipped, n_ends, n_settings;
   bit  quiet;
   bit  hold_off_pending;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("tb: failure");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      $display("tb: mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic void clear_decoder();
      want_hdr = 1'b1;
      pkt_run  = 1'b0;
      pkt_left = '0;
      byte_idx = '0;
      gather   = '0;
      done_cnt = '0;
      img_done = 1'b0;
   endfunction

   function automatic int unsigned eff_nb();
      if (cfg_pb == 0) return 1;
      if (cfg_pb > MAX_PIXEL_BYTES) return MAX_PIXEL_BYTES;
      return 32'(cfg_pb);
   endfunction

   function automatic bit image_over();
      return img_done || (done_cnt >= cfg_total);
   endfunction

   task automatic decode_byte(input logic [7:0] d, input logic fs, output bit used,
                              output bit hit, output pixel_run_type res);
      int unsigned           nb;
      logic [7:0]            cnt;
      logic [CNT_W-1:0]      room;
      logic [PIXEL_BITS-1:0] pix;
      used = 1'b0;
      hit  = 1'b0;
      res  = '0;
      nb   = eff_nb();
      if (fs) clear_decoder();
      if (image_over()) return;
      used = 1'b1;
      if (cfg_rle && want_hdr) begin
         pkt_run  = d[RUN_FLAG_BIT];
         pkt_left = {1'b0, d[6:0] & RUN_LEN_MASK} + 8'd1;
         want_hdr = 1'b0;
         byte_idx = '0;
         gather   = '0;
         return;
      end
      gather = gather | (PIXEL_BITS'(d) << (8 * byte_idx));
      if (byte_idx + 1 < nb) begin
         byte_idx = byte_idx + 2'd1;
         return;
      end
      pix      = gather;
      byte_idx = '0;
      gather   = '0;
      cnt      = 8'd1;
      if (cfg_rle) begin
         if (pkt_run) cnt = pkt_left;
         if (cnt > pkt_left) cnt = pkt_left;
         pkt_left = pkt_left - cnt;
         if (pkt_left == 0) want_hdr = 1'b1;
         if (cnt == 0) cnt = 8'd1;
      end
      room = cfg_total - done_cnt;
      res.run_clipped = (CNT_W'(cnt) > room);
      if (res.run_clipped) cnt = room[7:0];
      done_cnt = done_cnt + CNT_W'(cnt);
      if (done_cnt == cfg_total) img_done = 1'b1;
      if (nb >= 3 && cfg_swap) pix = {pix[31:24], pix[7:0], pix[15:8], pix[23:16]};
      res.pixel_value  = pix;
      res.repeat_count = cnt;
      res.image_end    = img_done;
      hit = 1'b1;
   endtask

   task automatic push_byte(input logic [7:0] d, input logic fs, input logic typed,
                            input pixel_run_type want);
      bit            used;
      bit            hit;
      pixel_run_type res;
      req_if.valid       <= 1'b1;
      req_if.data_byte   <= d;
      req_if.frame_start <= fs;
      do @(posedge clock); while (!req_if.ready);
      decode_byte(d, fs, used, hit, res);
      n_bytes++;
      if (used) n_used++;
      if (typed) pending_pixels.push_back(want);
      else if (hit) pending_pixels.push_back(res);
      if (!quiet && $urandom_range(0, 99) < 10) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_PIXEL_BYTES:   cfg_pb    = val[NB_BITS-1:0];
         CSR_RLE_MODE:      cfg_rle   = val[0];
         CSR_SWAP_RED_BLUE: cfg_swap  = val[0];
         CSR_TOTAL_PIXELS:  cfg_total = val[CNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_image(input int unsigned budget);
      int unsigned nb;
      int unsigned start;
      int unsigned roll;
      int unsigned len;
      int unsigned npix;
      logic        fs;
      logic [7:0]  hdr;
      logic [7:0]  chunk[$];
      nb    = eff_nb();
      start = n_bytes;
      fs    = 1'b1;
      while (fs || (!image_over() && n_bytes - start < budget)) begin
         chunk.delete();
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            fs = 1'b1;
            chunk.push_back(8'($urandom_range(0, 255)));
         end else if (roll < 10) begin
            chunk.push_back(8'($urandom_range(0, 255)));
         end else if (!cfg_rle) begin
            repeat (nb) chunk.push_back(8'($urandom_range(0, 255)));
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) len = $urandom_range(0, 7);
            else if (roll < 90) len = $urandom_range(8, 40);
            else len = $urandom_range(41, 127);
            hdr  = {1'($urandom_range(0, 1)), 7'(len)};
            npix = hdr[RUN_FLAG_BIT] ? 1 : len + 1;
            chunk.push_back(hdr);
            repeat (npix * nb) chunk.push_back(8'($urandom_range(0, 255)));
         end
         foreach (chunk[k]) begin
            if (fs || !image_over()) begin
               push_byte(chunk[k], fs, 1'b0, '0);
               fs = 1'b0;
            end
         end
      end
      repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
   endtask

   function automatic stim_row_type row_byte(input logic [7:0] d, input logic fs);
      stim_row_type r;
      r          = '0;
      r.reg_kind = ROW_BYTE;
      r.data     = d;
      r.fs       = fs;
      return r;
   endfunction

   function automatic stim_row_type row_want(input logic [7:0] d, input logic fs,
                                             input logic [PIXEL_BITS-1:0] pix,
                                             input logic [7:0] cnt, input logic e,
                                             input logic c);
      stim_row_type r;
      r       = row_byte(d, fs);
      r.typed = 1'b1;
      r.want  = '{pixel_value: pix, repeat_count: cnt, image_end: e, run_clipped: c};
      return r;
   endfunction

   function automatic stim_row_type row_reg(input csr_index_type idx,
                                            input logic [CSR_DATA_BITS-1:0] val);
      stim_row_type r;
      r          = '0;
      r.reg_kind = ROW_REG;
      r.reg_idx  = idx;
      r.wdata    = val;
      return r;
   endfunction

   // response side: random stalls, one long hold-off on request
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_if.ready <= quiet || ($urandom_range(0, 99) >= 17);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      pixel_run_type w;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         n_results++;
         if (rsp_if.repeat_count > 1) n_runs++;
         if (rsp_if.run_clipped) n_clipped++;
         if (rsp_if.image_end) n_ends++;
         if (pending_pixels.size() == 0) begin
            flag_mismatch($sformatf("unexpected pixel %h", rsp_if.pixel_value));
         end else begin
            w = pending_pixels.pop_front();
            if (rsp_if.pixel_value !== w.pixel_value)
               flag_mismatch($sformatf("pixel_value %h, want %h",
                                       rsp_if.pixel_value, w.pixel_value));
            if (rsp_if.repeat_count !== w.repeat_count)
               flag_mismatch($sformatf("repeat_count %0d, want %0d",
                                       rsp_if.repeat_count, w.repeat_count));
            if (rsp_if.image_end !== w.image_end)
               flag_mismatch($sformatf("image_end %b, want %b",
                                       rsp_if.image_end, w.image_end));
            if (rsp_if.run_clipped !== w.run_clipped)
               flag_mismatch($sformatf("run_clipped %b, want %b",
                                       rsp_if.run_clipped, w.run_clipped));
         end
      end
   end

   initial begin
      bit                  in_cfg;
      int                  phase;
      int                  dir_used;
      logic [NB_BITS-1:0]  pb;
      logic                rle;
      logic [CNT_W-1:0]    tot;
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.data_byte   <= '0;
      req_if.frame_start <= 1'b0;
      csr_we             <= 1'b0;
      csr_index          <= CSR_PIXEL_BYTES;
      csr_wdata          <= '0;
      mismatches = 0;
      n_bytes = 0;
      n_used = 0;
      n_results = 0;
      n_runs = 0;
      n_clipped = 0;
      n_ends = 0;
      n_settings = 1;
      quiet = 1'b0;
      hold_off_pending = 1'b0;
      cfg_pb    = RST_PIXEL_BYTES;
      cfg_rle   = RST_RLE_MODE;
      cfg_swap  = RST_SWAP;
      cfg_total = RST_TOTAL_PIXELS;
      clear_decoder();

      // reset settings: one run pixel completes the one-pixel image
      dir_tab.push_back(row_byte(8'h80, 1'b1));
      dir_tab.push_back(row_byte(8'h11, 1'b0));
      dir_tab.push_back(row_byte(8'h22, 1'b0));
      dir_tab.push_back(row_want(8'h33, 1'b0, 32'h0011_2233, 8'd1, 1'b1, 1'b0));
      dir_tab.push_back(row_byte(8'hFF, 1'b0));
      // longest run clipped to the image total
      dir_tab.push_back(row_reg(CSR_TOTAL_PIXELS, 25'd5));
      dir_tab.push_back(row_byte(8'hFF, 1'b1));
      dir_tab.push_back(row_byte(8'hAA, 1'b0));
      dir_tab.push_back(row_byte(8'hBB, 1'b0));
      dir_tab.push_back(row_want(8'hCC, 1'b0, 32'h00AA_BBCC, 8'd5, 1'b1, 1'b1));
      // four-byte literals, no swap, largest total
      dir_tab.push_back(row_reg(CSR_PIXEL_BYTES, 25'd4));
      dir_tab.push_back(row_reg(CSR_SWAP_RED_BLUE, 25'd0));
      dir_tab.push_back(row_reg(CSR_TOTAL_PIXELS, '1));
      dir_tab.push_back(row_byte(8'h00, 1'b1));
      dir_tab.push_back(row_byte(8'hFF, 1'b0));
      dir_tab.push_back(row_byte(8'h00, 1'b0));
      dir_tab.push_back(row_byte(8'hFF, 1'b0));
      dir_tab.push_back(row_want(8'h00, 1'b0, 32'h00FF_00FF, 8'd1, 1'b0, 1'b0));
      dir_tab.push_back(row_byte(8'h7F, 1'b0));
      dir_tab.push_back(row_byte(8'h01, 1'b0));
      dir_tab.push_back(row_byte(8'h80, 1'b0));
      dir_tab.push_back(row_byte(8'h7F, 1'b0));
      dir_tab.push_back(row_byte(8'hFE, 1'b0));
      // raw mode, zero pixel size taken as one byte
      dir_tab.push_back(row_reg(CSR_PIXEL_BYTES, 25'd0));
      dir_tab.push_back(row_reg(CSR_RLE_MODE, 25'd0));
      dir_tab.push_back(row_want(8'h5A, 1'b0, 32'h0000_005A, 8'd1, 1'b0, 1'b0));
      // empty image ignores everything, oversize pixel size
      dir_tab.push_back(row_reg(CSR_PIXEL_BYTES, 25'd7));
      dir_tab.push_back(row_reg(CSR_RLE_MODE, 25'd1));
      dir_tab.push_back(row_reg(CSR_SWAP_RED_BLUE, 25'd1));
      dir_tab.push_back(row_reg(CSR_TOTAL_PIXELS, 25'd0));
      dir_tab.push_back(row_byte(8'h81, 1'b1));
      // two-byte run, never swapped
      dir_tab.push_back(row_reg(CSR_PIXEL_BYTES, 25'd2));
      dir_tab.push_back(row_reg(CSR_TOTAL_PIXELS, 25'd16777216));
      dir_tab.push_back(row_byte(8'h81, 1'b1));
      dir_tab.push_back(row_byte(8'h34, 1'b0));
      dir_tab.push_back(row_want(8'h12, 1'b0, 32'h0000_1234, 8'd2, 1'b0, 1'b0));
      dir_tab.push_back(row_byte(8'h00, 1'b0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      in_cfg = 1'b0;
      foreach (dir_tab[i]) begin
         if (dir_tab[i].reg_kind == ROW_REG) begin
            if (!in_cfg) begin
               settle();
               n_settings++;
            end
            write_reg(dir_tab[i].reg_idx, dir_tab[i].wdata);
            in_cfg = 1'b1;
         end else begin
            if (in_cfg) csr_we <= 1'b0;
            in_cfg = 1'b0;
            push_byte(dir_tab[i].data, dir_tab[i].fs, dir_tab[i].typed, dir_tab[i].want);
         end
      end

      dir_used = n_used;
      phase = 0;
      while (n_used - dir_used < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 8) pb = NB_BITS'($urandom_range(1, 4));
         else if ($urandom_range(0, 3) == 0) pb = '0;
         else pb = NB_BITS'($urandom_range(5, 7));
         rle = ($urandom_range(0, 9) < 8);
         case ($urandom_range(0, 19))
            0:       tot = '0;
            1:       tot = '1;
            2:       tot = CNT_W'(16777216);
            3:       tot = CNT_W'($urandom_range(100, 3000));
            default: tot = CNT_W'($urandom_range(1, 48));
         endcase
         if (phase == STALL_PHASE) begin
            rle = 1'b0;
            tot = '1;
         end
         settle();
         write_reg(CSR_PIXEL_BYTES, CSR_DATA_BITS'(pb));
         write_reg(CSR_RLE_MODE, CSR_DATA_BITS'(rle));
         write_reg(CSR_SWAP_RED_BLUE, CSR_DATA_BITS'($urandom_range(0, 1)));
         write_reg(CSR_TOTAL_PIXELS, tot);
         csr_we <= 1'b0;
         n_settings++;
         quiet = (phase == QUIET_PHASE);
         if (phase == STALL_PHASE) hold_off_pending = 1'b1;
         repeat ($urandom_range(1, 4)) send_image($urandom_range(16, 160));
         quiet = 1'b0;
         phase++;
      end

      settle();
      $display("covered %0d bytes (%0d decoded) over %0d register settings",
               n_bytes, n_used, n_settings);
      $display("checked %0d pixel results: %0d runs, %0d clipped, %0d image ends",
               n_results, n_runs, n_clipped, n_ends);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
